// File: hdl/xmodem_block_sender_macros.svh
// Assertion helpers shared by the sender's modules.
`ifndef XMODEM_BLOCK_SENDER_MACROS_SVH
`define XMODEM_BLOCK_SENDER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define XBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds.
`define XBS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: hdl/xbs_pkg.sv
package xbs_pkg;

  localparam int unsigned PAYLOAD_BYTES = 128;
  localparam int unsigned QDEPTH        = 2;

  // input item kinds
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_REMOTE = 2'd1;
  localparam logic [1:0] OP_MEMORY = 2'd2;

  // link control characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_CRC = 8'h43;

  // status codes
  localparam logic [2:0] ST_RUN        = 3'd0;
  localparam logic [2:0] ST_DONE       = 3'd1;
  localparam logic [2:0] ST_NO_RX      = 3'd2;
  localparam logic [2:0] ST_RETRIES    = 3'd3;
  localparam logic [2:0] ST_CANCELLED  = 3'd4;
  localparam logic [2:0] ST_PROTO_ERR  = 3'd5;
  localparam logic [2:0] ST_BAD_FINAL  = 3'd6;

  // configuration register indexes
  localparam logic [1:0] REG_START_ADDR = 2'd0;
  localparam logic [1:0] REG_LAST_BLOCK = 2'd1;
  localparam logic [1:0] REG_RETRY_LIM  = 2'd2;

  // one descriptor: one to three result transfers
  typedef struct packed {
    logic [1:0]      last_idx;  // index of the final transfer
    logic            txv;
    logic [2:0][7:0] bytes;
    logic            rreq;      // read request rides on the final transfer
    logic [19:0]     addr;
    logic [2:0]      status;
  } xbs_desc_t;

  // CRC-16/XMODEM, one byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ 16'h1021;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/xbs_front.sv
module xbs_front #(
  parameter int unsigned ADDRESS_BITS = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [19:0]       cfg_data_i,
  input  logic              in_acc_i,
  input  logic [1:0]        op_i,
  input  logic [7:0]        remote_byte_i,
  input  logic [7:0]        memory_byte_i,
  output logic              push_o,
  output xbs_pkg::xbs_desc_t desc_o
);

  localparam int unsigned AW = ADDRESS_BITS;

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_WAIT_FIRST = 3'd1;
  localparam logic [2:0] PH_READING    = 3'd2;
  localparam logic [2:0] PH_WAIT_REPLY = 3'd3;
  localparam logic [2:0] PH_WAIT_FINAL = 3'd4;

  logic [19:0]   start_q;
  logic [13:0]   lastb_q;
  logic [3:0]    limit_q;

  logic [2:0]    phase_q, phase_d;
  logic [AW-1:0] cur_q, cur_d, bsa_q, bsa_d;
  logic [13:0]   bn_q, bn_d;
  logic [7:0]    bc_q, bc_d;
  logic [3:0]    rc_q, rc_d;
  logic          crcm_q, crcm_d;
  logic [15:0]   crc_q, crc_d;
  logic [7:0]    sum_q, sum_d;

  logic [AW-1:0] cur_inc;
  logic [7:0]    bc_inc;
  logic [3:0]    rc_inc;
  logic [13:0]   bn_inc;
  logic [15:0]   crc_new;
  logic [7:0]    sum_new;
  logic          blk, rep;
  logic [7:0]    blk_num;
  logic [AW-1:0] blk_addr;
  logic [2:0]    rep_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      lastb_q <= 14'd8192;
      limit_q <= 4'd10;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        xbs_pkg::REG_START_ADDR: start_q <= cfg_data_i;
        xbs_pkg::REG_LAST_BLOCK: lastb_q <= cfg_data_i[13:0];
        xbs_pkg::REG_RETRY_LIM:  limit_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign cur_inc = cur_q + AW'(1);
  assign bc_inc  = bc_q + 8'd1;
  assign rc_inc  = rc_q + 4'd1;
  assign bn_inc  = bn_q + 14'd1;
  assign crc_new = xbs_pkg::crc16_byte(crc_q, memory_byte_i);
  assign sum_new = sum_q + memory_byte_i;

  always_comb begin
    phase_d    = phase_q;
    cur_d      = cur_q;
    bsa_d      = bsa_q;
    bn_d       = bn_q;
    bc_d       = bc_q;
    rc_d       = rc_q;
    crcm_d     = crcm_q;
    crc_d      = crc_q;
    sum_d      = sum_q;
    push_o     = 1'b0;
    desc_o     = '0;
    blk        = 1'b0;
    blk_num    = bn_q[7:0];
    blk_addr   = cur_q;
    rep        = 1'b0;
    rep_status = xbs_pkg::ST_RUN;

    if (in_acc_i) begin
      case (op_i)
        xbs_pkg::OP_START: begin
          phase_d = PH_WAIT_FIRST;
          cur_d   = AW'(start_q);
          bsa_d   = AW'(start_q);
          bn_d    = 14'd1;
          bc_d    = '0;
          rc_d    = '0;
          crcm_d  = 1'b0;
          crc_d   = '0;
          sum_d   = '0;
        end
        xbs_pkg::OP_MEMORY: begin
          if (phase_q == PH_READING) begin
            crc_d  = crc_new;
            sum_d  = sum_new;
            cur_d  = cur_inc;
            bc_d   = bc_inc;
            push_o = 1'b1;
            desc_o.txv      = 1'b1;
            desc_o.bytes[0] = memory_byte_i;
            if (bc_inc < 8'(xbs_pkg::PAYLOAD_BYTES)) begin
              desc_o.rreq = 1'b1;
              desc_o.addr = 20'(cur_inc);
            end else begin
              phase_d = PH_WAIT_REPLY;
              if (crcm_q) begin
                desc_o.last_idx = 2'd2;
                desc_o.bytes[1] = crc_new[15:8];
                desc_o.bytes[2] = crc_new[7:0];
              end else begin
                desc_o.last_idx = 2'd1;
                desc_o.bytes[1] = sum_new;
              end
            end
          end
        end
        xbs_pkg::OP_REMOTE: begin
          case (phase_q)
            PH_WAIT_FIRST: begin
              if (remote_byte_i == xbs_pkg::CH_NAK || remote_byte_i == xbs_pkg::CH_CRC) begin
                crcm_d = (remote_byte_i == xbs_pkg::CH_CRC);
                rc_d   = '0;
                blk    = 1'b1;
              end else begin
                rep        = 1'b1;
                rep_status = xbs_pkg::ST_NO_RX;
                phase_d    = PH_IDLE;
              end
            end
            PH_WAIT_REPLY: begin
              if (remote_byte_i == xbs_pkg::CH_ACK) begin
                rc_d = '0;
                bn_d = bn_inc;
                if (bn_q >= lastb_q) begin
                  phase_d         = PH_WAIT_FINAL;
                  push_o          = 1'b1;
                  desc_o.txv      = 1'b1;
                  desc_o.bytes[0] = xbs_pkg::CH_EOT;
                end else begin
                  bsa_d   = cur_q;
                  blk     = 1'b1;
                  blk_num = bn_inc[7:0];
                end
              end else if (remote_byte_i == xbs_pkg::CH_NAK) begin
                rc_d = rc_inc;
                if (rc_inc >= limit_q) begin
                  rep        = 1'b1;
                  rep_status = xbs_pkg::ST_RETRIES;
                  phase_d    = PH_IDLE;
                end else begin
                  // rewind to the start of the block
                  cur_d    = bsa_q;
                  blk      = 1'b1;
                  blk_addr = bsa_q;
                end
              end else if (remote_byte_i == xbs_pkg::CH_CAN) begin
                rep        = 1'b1;
                rep_status = xbs_pkg::ST_CANCELLED;
                phase_d    = PH_IDLE;
              end else if (remote_byte_i == xbs_pkg::CH_CRC) begin
                rep        = 1'b1;
                rep_status = xbs_pkg::ST_PROTO_ERR;
                phase_d    = PH_IDLE;
              end
            end
            PH_WAIT_FINAL: begin
              rep = 1'b1;
              if (remote_byte_i == xbs_pkg::CH_ACK) begin
                rep_status = xbs_pkg::ST_DONE;
                phase_d    = PH_IDLE;
              end else begin
                rep_status = xbs_pkg::ST_BAD_FINAL;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase

      if (blk) begin
        bc_d    = '0;
        crc_d   = '0;
        sum_d   = '0;
        phase_d = PH_READING;
        push_o  = 1'b1;
        desc_o.last_idx = 2'd2;
        desc_o.txv      = 1'b1;
        desc_o.bytes[0] = xbs_pkg::CH_SOH;
        desc_o.bytes[1] = blk_num;
        desc_o.bytes[2] = ~blk_num;
        desc_o.rreq     = 1'b1;
        desc_o.addr     = 20'(blk_addr);
      end
      if (rep) begin
        push_o        = 1'b1;
        desc_o.status = rep_status;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cur_q   <= '0;
      bsa_q   <= '0;
      bn_q    <= '0;
      bc_q    <= '0;
      rc_q    <= '0;
      crcm_q  <= 1'b0;
      crc_q   <= '0;
      sum_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cur_q   <= cur_d;
      bsa_q   <= bsa_d;
      bn_q    <= bn_d;
      bc_q    <= bc_d;
      rc_q    <= rc_d;
      crcm_q  <= crcm_d;
      crc_q   <= crc_d;
      sum_q   <= sum_d;
    end
  end

  `include "xmodem_block_sender_macros.svh"

  `XBS_ASSERT(a_read_ends_block, (in_acc_i && op_i == xbs_pkg::OP_MEMORY && phase_q == PH_READING) |=> (phase_q == PH_READING || phase_q == PH_WAIT_REPLY), "read data left the block body")
  `XBS_ASSERT(a_count_in_body, (phase_q == PH_READING) |-> (bc_q < 8'(xbs_pkg::PAYLOAD_BYTES)), "byte count past payload")

endmodule

// File: hdl/xbs_fifo.sv
module xbs_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  xbs_pkg::xbs_desc_t wdata_i,
  input  logic               pop_i,
  output xbs_pkg::xbs_desc_t rdata_o,
  output logic               empty_o,
  output logic               full_o
);

  localparam int unsigned PW = (xbs_pkg::QDEPTH > 1) ? $clog2(xbs_pkg::QDEPTH) : 1;
  localparam int unsigned CW = $clog2(xbs_pkg::QDEPTH + 1);

  xbs_pkg::xbs_desc_t slot_q [xbs_pkg::QDEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(xbs_pkg::QDEPTH));
  assign rdata_o = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(xbs_pkg::QDEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(xbs_pkg::QDEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  `include "xmodem_block_sender_macros.svh"

  `XBS_NEVER(a_no_overflow, push_i && full_o, "descriptor pushed into full queue")
  `XBS_NEVER(a_no_underflow, pop_i && empty_o, "descriptor popped from empty queue")

endmodule

// File: hdl/xbs_back.sv
module xbs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  xbs_pkg::xbs_desc_t desc_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [31:0]        data_o,
  output logic [1:0]         user_o,
  output logic               last_o
);

  logic [1:0]  idx_q;
  logic        at_last, rreq;
  logic [19:0] addr;

  assign valid_o = !empty_i;
  assign at_last = (idx_q == desc_i.last_idx);
  assign last_o  = at_last;
  assign pop_o   = valid_o && ready_i && at_last;
  assign rreq    = desc_i.rreq && at_last;
  assign addr    = rreq ? desc_i.addr : '0;
  assign data_o  = {1'b0, desc_i.status, addr, desc_i.bytes[idx_q]};
  assign user_o  = {rreq, desc_i.txv};

  // step through the descriptor's transfers, restart on the next one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (valid_o && ready_i) begin
      idx_q <= at_last ? '0 : idx_q + 2'd1;
    end
  end

  `include "xmodem_block_sender_macros.svh"

  `XBS_ASSERT(a_idx_in_desc, valid_o |-> (idx_q <= desc_i.last_idx), "transfer index past descriptor")

endmodule

// File: hdl/xmodem_block_sender.sv
// XMODEM block sender: uploads a memory range as 128-byte blocks with an 8-bit
// sum or CRC-16 check, picked by the remote's first byte. Input items (start,
// remote byte, memory read data) are taken one per cycle whenever the two-entry
// descriptor queue between the protocol engine and the output side has room;
// items that cause no results never occupy it. Results leave one per cycle while
// the output is ready; a header is three results, a data byte one and the final data
// byte two or three with its check. The per-byte CRC update completes in the
// cycle the byte is accepted. No memory clearing pass follows reset.
module xmodem_block_sender #(
  parameter int unsigned ADDRESS_BITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // remote_byte, memory_byte
  input  logic [1:0]  s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // tx_byte, read_address, status, zero pad
  output logic [1:0]  m_axis_tuser,   // tx_valid, read_request
  output logic        m_axis_tlast
);

  logic               in_acc, push, pop, empty, full;
  xbs_pkg::xbs_desc_t wdesc, rdesc;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !full;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  xbs_front #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_acc_i      (in_acc),
    .op_i          (s_axis_tuser),
    .remote_byte_i (s_axis_tdata[7:0]),
    .memory_byte_i (s_axis_tdata[15:8]),
    .push_o        (push),
    .desc_o        (wdesc)
  );

  xbs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wdesc),
    .pop_i   (pop),
    .rdata_o (rdesc),
    .empty_o (empty),
    .full_o  (full)
  );

  xbs_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .desc_i  (rdesc),
    .empty_i (empty),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata),
    .user_o  (m_axis_tuser),
    .last_o  (m_axis_tlast)
  );

endmodule

// File: verif/xmodem_block_sender_tb.sv
`timescale 1ns / 100ps

module xmodem_block_sender_tb;

  localparam logic [1:0]  OP_NOP        = 2'd3;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam int          DIR_ROWS      = 25;
  localparam int          RANDOM_ITEMS  = 175;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLD_AT       = 80;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          TAIL_CYCLES   = 20;

  typedef enum logic [2:0] {
    SND_IDLE, SND_WAIT_FIRST, SND_READING, SND_WAIT_REPLY, SND_WAIT_FINAL
  } snd_phase_e;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_QUIET, ROW_REPORT} row_form_e;

  typedef struct packed {
    logic        txv;
    logic [7:0]  tx_byte;
    logic        rreq;
    logic [19:0] addr;
    logic [2:0]  status;
    logic        last;
  } link_xfer_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rb;
    logic [7:0] mb;
    row_form_e  form;
    logic [2:0] status;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [19:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // remote_byte, memory_byte
  logic [1:0]  s_axis_tuser;   // op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // tx_byte, read_address, status, zero pad
  logic [1:0]  m_axis_tuser;   // tx_valid, read_request
  logic        m_axis_tlast;

  xmodem_block_sender u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // register copies, reset values
  logic [19:0] cfg_start    = '0;
  logic [13:0] cfg_last_blk = 14'd8192;
  logic [3:0]  cfg_retries  = 4'd10;

  // sender state as predicted
  snd_phase_e  ph       = SND_IDLE;
  logic [19:0] cur_addr = '0;
  logic [19:0] blk_addr = '0;
  logic [13:0] blk_num  = '0;
  logic [7:0]  byte_cnt = '0;
  logic [3:0]  nak_cnt  = '0;
  logic        crc_on   = 1'b0;
  logic [15:0] crc      = '0;
  logic [7:0]  sum      = '0;

  link_xfer_t  pend [3];
  int          pend_n;
  link_xfer_t  upload_q [$];

  int items_taken   = 0;
  int xfers_checked = 0;
  int blocks_opened = 0;
  int eots_sent     = 0;
  int reg_writes    = 0;
  int cfg_round     = 0;
  int fail_cnt      = 0;
  bit steady        = 1'b0;

  stim_row_t dir_table [DIR_ROWS] = '{
    // remote byte while idle, memory data with no read outstanding
    '{xbs_pkg::OP_REMOTE, xbs_pkg::CH_ACK, 8'h00, ROW_QUIET,   xbs_pkg::ST_RUN},
    '{xbs_pkg::OP_MEMORY, 8'h00,           8'hFF, ROW_QUIET,   xbs_pkg::ST_RUN},
    '{OP_NOP,             8'hFF,           8'hFF, ROW_QUIET,   xbs_pkg::ST_RUN},
    '{xbs_pkg::OP_START,  8'h00,           8'h00, ROW_QUIET,   xbs_pkg::ST_RUN},
    '{xbs_pkg::OP_REMOTE, 8'h00,           8'h00, ROW_REPORT,  xbs_pkg::ST_NO_RX},
    '{xbs_pkg::OP_START,  8'h00,           8'h00, ROW_QUIET,   xbs_pkg::ST_RUN},
    '{xbs_pkg::OP_REMOTE, 8'hFF,           8'h00, ROW_REPORT,  xbs_pkg::ST_NO_RX},
    '{xbs_pkg::OP_START,  8'h00,           8'h00, ROW_QUIET,   xbs_pkg::ST_RUN},
    '{xbs_pkg::OP_REMOTE, xbs_pkg::CH_CRC, 8'h00, ROW_PREDICT, xbs_pkg::ST_RUN},
    // ignored while reading
    '{xbs_pkg::OP_REMOTE, xbs_pkg::CH_ACK, 8'h00, ROW_QUIET,   xbs_pkg::ST_RUN},
    '{xbs_pkg::OP_MEMORY, 8'h00,           8'h00, ROW_PREDICT, xbs_pkg::ST_RUN},
    '{xbs_pkg::OP_MEMORY, 8'h00,           8'hFF, ROW_PREDICT, xbs_pkg::ST_RUN},
    '{OP_NOP,             8'h00,           8'h00, ROW_QUIET,   xbs_pkg::ST_RUN},
    // start while busy
    '{xbs_pkg::OP_START,  8'h00,           8'h00, ROW_QUIET,   xbs_pkg::ST_RUN},
    '{xbs_pkg::OP_MEMORY, 8'h00,           8'h5A, ROW_QUIET,   xbs_pkg::ST_RUN},
    '{xbs_pkg::OP_REMOTE, xbs_pkg::CH_NAK, 8'h00, ROW_PREDICT, xbs_pkg::ST_RUN},
    '{xbs_pkg::OP_MEMORY, 8'h00,           8'hA5, ROW_PREDICT, xbs_pkg::ST_RUN},
    '{xbs_pkg::OP_MEMORY, 8'h00,           8'h5A, ROW_PREDICT, xbs_pkg::ST_RUN},
    '{xbs_pkg::OP_REMOTE, xbs_pkg::CH_CAN, 8'h00, ROW_QUIET,   xbs_pkg::ST_RUN},
    '{xbs_pkg::OP_START,  8'h00,           8'h00, ROW_QUIET,   xbs_pkg::ST_RUN},
    '{xbs_pkg::OP_REMOTE, xbs_pkg::CH_CAN, 8'h00, ROW_REPORT,  xbs_pkg::ST_NO_RX},
    '{xbs_pkg::OP_START,  8'h00,           8'h00, ROW_QUIET,   xbs_pkg::ST_RUN},
    '{xbs_pkg::OP_REMOTE, xbs_pkg::CH_CRC, 8'h00, ROW_PREDICT, xbs_pkg::ST_RUN},
    '{xbs_pkg::OP_START,  8'h00,           8'h00, ROW_QUIET,   xbs_pkg::ST_RUN},
    '{xbs_pkg::OP_REMOTE, xbs_pkg::CH_ACK, 8'h00, ROW_REPORT,  xbs_pkg::ST_NO_RX}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [15:0] crc_after(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ d[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  task emit(input logic txv, input logic [7:0] b, input logic rreq,
            input logic [19:0] addr, input logic [2:0] status);
    pend[pend_n] = '{txv, b, rreq, addr, status, 1'b0};
    pend_n++;
  endtask

  task open_block();
    byte_cnt = '0;
    crc      = '0;
    sum      = '0;
    ph       = SND_READING;
    emit(1'b1, xbs_pkg::CH_SOH, 1'b0, '0, xbs_pkg::ST_RUN);
    emit(1'b1, blk_num[7:0], 1'b0, '0, xbs_pkg::ST_RUN);
    emit(1'b1, ~blk_num[7:0], 1'b1, cur_addr, xbs_pkg::ST_RUN);
    blocks_opened++;
  endtask

  task report(input logic [2:0] status, input snd_phase_e next_ph);
    ph = next_ph;
    emit(1'b0, 8'h00, 1'b0, '0, status);
  endtask

  // advance the sender by one input transfer; results land in pend
  task step_upload(input logic [1:0] op, input logic [7:0] rb, input logic [7:0] mb);
    pend_n = 0;
    case (op)
      xbs_pkg::OP_START: begin
        ph       = SND_WAIT_FIRST;
        cur_addr = cfg_start;
        blk_addr = cfg_start;
        blk_num  = 14'd1;
        byte_cnt = '0;
        nak_cnt  = '0;
        crc_on   = 1'b0;
        crc      = '0;
        sum      = '0;
      end
      xbs_pkg::OP_MEMORY: begin
        if (ph == SND_READING) begin
          crc      = crc_after(crc, mb);
          sum      = sum + mb;
          cur_addr = cur_addr + 20'd1;
          byte_cnt = byte_cnt + 8'd1;
          if (byte_cnt < xbs_pkg::PAYLOAD_BYTES) begin
            emit(1'b1, mb, 1'b1, cur_addr, xbs_pkg::ST_RUN);
          end else begin
            emit(1'b1, mb, 1'b0, '0, xbs_pkg::ST_RUN);
            if (crc_on) begin
              emit(1'b1, crc[15:8], 1'b0, '0, xbs_pkg::ST_RUN);
              emit(1'b1, crc[7:0], 1'b0, '0, xbs_pkg::ST_RUN);
            end else begin
              emit(1'b1, sum, 1'b0, '0, xbs_pkg::ST_RUN);
            end
            ph = SND_WAIT_REPLY;
          end
        end
      end
      xbs_pkg::OP_REMOTE: begin
        case (ph)
          SND_WAIT_FIRST: begin
            if (rb == xbs_pkg::CH_NAK || rb == xbs_pkg::CH_CRC) begin
              crc_on  = (rb == xbs_pkg::CH_CRC);
              nak_cnt = '0;
              open_block();
            end else begin
              report(xbs_pkg::ST_NO_RX, SND_IDLE);
            end
          end
          SND_WAIT_REPLY: begin
            if (rb == xbs_pkg::CH_ACK) begin
              nak_cnt = '0;
              if (blk_num >= cfg_last_blk) begin
                blk_num = blk_num + 14'd1;
                ph      = SND_WAIT_FINAL;
                emit(1'b1, xbs_pkg::CH_EOT, 1'b0, '0, xbs_pkg::ST_RUN);
                eots_sent++;
              end else begin
                blk_num  = blk_num + 14'd1;
                blk_addr = cur_addr;
                open_block();
              end
            end else if (rb == xbs_pkg::CH_NAK) begin
              nak_cnt = nak_cnt + 4'd1;
              if (nak_cnt >= cfg_retries) begin
                report(xbs_pkg::ST_RETRIES, SND_IDLE);
              end else begin
                // rewind to the start of the block and resend
                cur_addr = blk_addr;
                open_block();
              end
            end else if (rb == xbs_pkg::CH_CAN) begin
              report(xbs_pkg::ST_CANCELLED, SND_IDLE);
            end else if (rb == xbs_pkg::CH_CRC) begin
              report(xbs_pkg::ST_PROTO_ERR, SND_IDLE);
            end
          end
          SND_WAIT_FINAL: begin
            if (rb == xbs_pkg::CH_ACK) begin
              report(xbs_pkg::ST_DONE, SND_IDLE);
            end else begin
              report(xbs_pkg::ST_BAD_FINAL, SND_WAIT_FINAL);
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (pend_n > 0) begin
      pend[pend_n - 1].last = 1'b1;
    end
  endtask

  task automatic send_item(input logic [1:0] op, input logic [7:0] rb, input logic [7:0] mb,
                           input row_form_e form, input logic [2:0] rep_status);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {mb, rb};
    do @(posedge clk_i); while (!s_axis_tready);
    items_taken++;
    step_upload(op, rb, mb);
    if (form == ROW_PREDICT) begin
      for (int i = 0; i < pend_n; i++) begin
        upload_q.push_back(pend[i]);
      end
    end else if (form == ROW_REPORT) begin
      upload_q.push_back('{1'b0, 8'h00, 1'b0, 20'h0, rep_status, 1'b1});
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [19:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      xbs_pkg::REG_START_ADDR: cfg_start    = val;
      xbs_pkg::REG_LAST_BLOCK: cfg_last_blk = val[13:0];
      xbs_pkg::REG_RETRY_LIM:  cfg_retries  = val[3:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // first rounds walk the extremes, later ones pick at random
  function automatic logic [19:0] cfg_value(input logic [1:0] idx, input int k);
    logic [19:0] v;
    v = '0;
    case (idx)
      xbs_pkg::REG_START_ADDR: begin
        case (k)
          0: v = 20'h00000;
          1: v = 20'hFFFFF;
          2: v = 20'hFFFC0;   // wraps inside the first block
          3: v = 20'h00080;
          default: v = 20'($urandom_range(0, 20'hFFFFF));
        endcase
      end
      xbs_pkg::REG_LAST_BLOCK: begin
        case (k)
          0: v = 20'd1;
          1: v = 20'd0;
          2: v = 20'd16383;
          3: v = 20'd2;
          default: v = 20'($urandom_range(1, 3));
        endcase
      end
      default: begin
        case (k)
          0: v = 20'd1;
          1: v = 20'd15;
          2: v = 20'd0;
          3: v = 20'd2;
          default: v = 20'($urandom_range(1, 15));
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic reconfigure();
    int         k;
    logic [2:0] mask;
    k    = (cfg_round < 5) ? cfg_round : $urandom_range(0, 4);
    mask = (cfg_round < 5) ? 3'b111 : 3'($urandom_range(1, 7));
    s_axis_tvalid <= 1'b0;
    while (upload_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mask[0]) begin
      cfg_write(xbs_pkg::REG_START_ADDR, cfg_value(xbs_pkg::REG_START_ADDR, k));
    end
    if (mask[1]) begin
      cfg_write(xbs_pkg::REG_LAST_BLOCK, cfg_value(xbs_pkg::REG_LAST_BLOCK, k));
    end
    if (mask[2]) begin
      cfg_write(xbs_pkg::REG_RETRY_LIM, cfg_value(xbs_pkg::REG_RETRY_LIM, k));
    end
    cfg_valid_i <= 1'b0;
    cfg_round++;
  endtask

  // choose the next item from where the upload stands, mostly well-formed
  task automatic pick_item(output logic [1:0] op, output logic [7:0] rb,
                           output logic [7:0] mb);
    int r;
    r  = $urandom_range(0, 999);
    rb = 8'($urandom_range(0, 255));
    mb = 8'($urandom_range(0, 255));
    op = xbs_pkg::OP_REMOTE;
    case (ph)
      SND_IDLE: begin
        if (r < 880)      op = xbs_pkg::OP_START;
        else if (r < 920) op = xbs_pkg::OP_REMOTE;
        else if (r < 960) op = xbs_pkg::OP_MEMORY;
        else              op = OP_NOP;
      end
      SND_WAIT_FIRST: begin
        if (r < 420)      rb = xbs_pkg::CH_NAK;
        else if (r < 840) rb = xbs_pkg::CH_CRC;
        else if (r < 950) op = xbs_pkg::OP_REMOTE;
        else if (r < 970) op = xbs_pkg::OP_START;
        else if (r < 990) op = xbs_pkg::OP_MEMORY;
        else              op = OP_NOP;
      end
      SND_READING: begin
        if (r < 985)      op = xbs_pkg::OP_MEMORY;
        else if (r < 993) op = xbs_pkg::OP_REMOTE;
        else if (r < 999) op = OP_NOP;
        else              op = xbs_pkg::OP_START;
      end
      SND_WAIT_REPLY: begin
        if (blk_num >= 14'd3) begin
          // cut long uploads short
          if (r < 400)      rb = xbs_pkg::CH_CAN;
          else if (r < 700) rb = xbs_pkg::CH_CRC;
          else if (r < 850) rb = xbs_pkg::CH_NAK;
          else              rb = xbs_pkg::CH_ACK;
        end else begin
          if (r < 550)      rb = xbs_pkg::CH_ACK;
          else if (r < 750) rb = xbs_pkg::CH_NAK;
          else if (r < 800) rb = xbs_pkg::CH_CAN;
          else if (r < 840) rb = xbs_pkg::CH_CRC;
          else if (r < 940) op = xbs_pkg::OP_REMOTE;
          else if (r < 970) op = xbs_pkg::OP_MEMORY;
          else              op = xbs_pkg::OP_START;
        end
      end
      default: begin
        if (r < 650)      rb = xbs_pkg::CH_ACK;
        else if (r < 900) op = xbs_pkg::OP_REMOTE;
        else if (r < 950) rb = xbs_pkg::CH_NAK;
        else if (r < 970) op = xbs_pkg::OP_START;
        else              op = OP_NOP;
      end
    endcase
  endtask

  task automatic check_field(input string what, input logic [19:0] want, input logic [19:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
      fail_cnt++;
    end
  endtask

  initial begin : link_receiver
    int stall_left;
    int hold_left;
    bit held_once;
    stall_left    = 0;
    hold_left     = 0;
    held_once     = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!held_once && items_taken >= HOLD_AT) begin
        // hold off long enough for the block to fill and stall its input
        held_once = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : result_monitor
    link_xfer_t got;
    link_xfer_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.txv     = m_axis_tuser[0];
        got.rreq    = m_axis_tuser[1];
        got.tx_byte = m_axis_tdata[7:0];
        got.addr    = m_axis_tdata[27:8];
        got.status  = m_axis_tdata[30:28];
        got.last    = m_axis_tlast;
        // let the sender side log the item accepted at this edge first
        #1;
        if (upload_q.size() == 0) begin
          $display("%0t: unexpected transfer: expected none, actual %0h", $time, got);
          fail_cnt++;
        end else begin
          want = upload_q.pop_front();
          check_field("tx_valid", want.txv, got.txv);
          check_field("tx_byte", want.tx_byte, got.tx_byte);
          check_field("read_request", want.rreq, got.rreq);
          check_field("read_address", want.addr, got.addr);
          check_field("status", want.status, got.status);
          check_field("last", want.last, got.last);
          xfers_checked++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [1:0] op;
    logic [7:0] rb;
    logic [7:0] mb;
    int         effective;
    bit         may_reconf;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    effective     = 0;
    may_reconf    = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(dir_table[i].op, dir_table[i].rb, dir_table[i].mb,
                dir_table[i].form, dir_table[i].status);
    end

    while (effective < RANDOM_ITEMS) begin
      if (ph != SND_IDLE) begin
        may_reconf = 1'b1;
      end else if (may_reconf) begin
        if (cfg_round < 6 || $urandom_range(0, 2) == 0) begin
          reconfigure();
        end
        may_reconf = 1'b0;
      end
      steady = (effective >= RANDOM_ITEMS * 4 / 5);
      pick_item(op, rb, mb);
      send_item(op, rb, mb, ROW_PREDICT, xbs_pkg::ST_RUN);
      if (op == xbs_pkg::OP_START || pend_n > 0) begin
        effective++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (upload_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d input transfers over %0d register settings (%0d writes).",
             items_taken, cfg_round + 1, reg_writes);
    $display("Checked %0d result transfers: %0d blocks opened, %0d EOTs sent.",
             xfers_checked, blocks_opened, eots_sent);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
